// ----- src/circular_lagrange_neighbour_weights_assert.svh -----
// Assertion macros shared by the checker files of this block.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef CIRCULAR_LAGRANGE_NEIGHBOUR_WEIGHTS_ASSERT_SVH
`define CIRCULAR_LAGRANGE_NEIGHBOUR_WEIGHTS_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define CLN_ASSERT_NOW(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Condition holds in the cycle after the trigger.
`define CLN_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ----- src/cln_pkg.sv -----
// Shared constants and codes for the circular Lagrange neighbour weight block.
// No dependencies.
package cln_pkg;

    localparam int MAX_DIR   = 64;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int ANG_W     = 16;
    localparam int WT_W      = 18;
    localparam int FRAC_BITS = 16;

    // Input word commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Register indexes on the configuration port
    localparam logic REG_NUM_DIR = 1'b0;
    localparam logic REG_ORDER   = 1'b1;

    localparam logic [CNT_W-1:0] NUM_DIR_RESET = 7'd16;
    localparam logic             ORDER_RESET   = 1'b1;

endpackage

// ----- src/cln_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cln_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/circular_lagrange_neighbour_weights.sv -----
// Top level: direction table, nearest search, neighbour pick and weight unit.
// Depends on cln_pkg and cln_ram.
//
// A load word writes one angle into the table. A query word scans the
// first n table entries, one per cycle through the table RAM read port,
// then reads two or four neighbours and computes each weight with a shared
// 32x16 multiplier and a restoring divider that yields one quotient bit
// per cycle. After a query is accepted the input stays stalled through
// the scan, the neighbour reads, then per weight the partial products of
// each factor plus the division. A weight that saturates early skips its
// division, repeated neighbour angles skip the weights, and a query with
// n zero goes straight to the result with fault set. A stalled result
// register adds its stall time. A finished word waits in the output
// register while the next word is accepted.
module circular_lagrange_neighbour_weights
    import cln_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // input channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    command,
    input  logic [IDX_W-1:0]        dir_index,
    input  logic [ANG_W-1:0]        angle,
    // output channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [IDX_W-1:0]        nbr_a,
    output logic [IDX_W-1:0]        nbr_b,
    output logic [IDX_W-1:0]        nbr_c,
    output logic [IDX_W-1:0]        nbr_d,
    output logic signed [WT_W-1:0]  wt_a,
    output logic signed [WT_W-1:0]  wt_b,
    output logic signed [WT_W-1:0]  wt_c,
    output logic signed [WT_W-1:0]  wt_d,
    output logic                    fault
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_PICK, S_RDN, S_FLT, S_MUL, S_DPRE, S_DIV, S_RND, S_OUT
    } state_t;

    localparam logic [ANG_W-1:0] HALF = 16'h8000;
    localparam logic [WT_W-1:0]  WLIM = 18'h20000;

    state_t             state_reg;
    logic [CNT_W-1:0]   num_dir_reg;
    logic               order_reg;
    logic [ANG_W-1:0]   phi_reg;
    logic [CNT_W-1:0]   n_reg;
    logic               cubic_reg;
    logic [CNT_W-1:0]   issue_reg;
    logic               pend_reg;
    logic [IDX_W-1:0]   pend_idx_reg;
    logic [ANG_W:0]     best_dist_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [ANG_W-1:0]   best_ang_reg;
    logic [IDX_W-1:0]   cur_reg;
    logic [IDX_W-1:0]   nb_reg [4];
    logic [ANG_W-1:0]   p_reg [4];
    logic [1:0]         wi_reg;
    logic [2:0]         j_reg;
    logic [1:0]         ph_reg;
    logic [63:0]        num_reg;
    logic [63:0]        den_reg;
    logic [47:0]        lo_reg;
    logic               neg_reg;
    logic [63:0]        rem_reg;
    logic [67:0]        dsh_reg;
    logic [18:0]        q_reg;
    logic [4:0]         step_reg;
    logic               sat_reg;
    logic signed [WT_W-1:0] wt_reg [4];
    logic               fault_reg;

    logic               out_valid_reg;
    logic [IDX_W-1:0]   o_nb_reg [4];
    logic signed [WT_W-1:0] o_wt_reg [4];
    logic               o_fault_reg;

    // table RAM
    logic               ram_we;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ANG_W-1:0]   ram_q;

    cln_ram #(.WIDTH(ANG_W), .DEPTH(MAX_DIR)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (dir_index),
        .wdata (angle),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    logic in_acc;
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign ram_we   = in_acc && (command == CMD_LOAD);
    assign ram_raddr = (state_reg == S_SCAN) ? issue_reg[IDX_W-1:0] : cur_reg;

    // result register takes a new word when it is empty or being drained
    logic out_load;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    // configuration port
    logic apb_wr;
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_NUM_DIR: prdata = {25'b0, num_dir_reg};
            REG_ORDER:   prdata = {31'b0, order_reg};
            default:     prdata = 32'b0;
        endcase
    end

    // wrap-around distance of the word just read during the scan
    logic [ANG_W-1:0] delta;
    logic [ANG_W:0]   wrapd;
    logic [ANG_W:0]   near_dist;
    always_comb
    begin
        delta     = (ram_q >= phi_reg) ? ram_q - phi_reg : phi_reg - ram_q;
        wrapd     = 17'h10000 - {1'b0, delta};
        near_dist = ({1'b0, delta} < wrapd) ? {1'b0, delta} : wrapd;
    end

    logic [2:0] cnt;
    assign cnt = cubic_reg ? 3'd4 : 3'd2;

    // start index of the neighbour run
    logic [ANG_W-1:0]  rot;
    logic [1:0]        back;
    logic signed [8:0] st0, st1, st2;
    always_comb
    begin
        rot  = best_ang_reg + HALF - phi_reg;
        if (cubic_reg)
        begin
            back = (rot < HALF) ? 2'd1 : 2'd2;
        end
        else
        begin
            back = (rot < HALF) ? 2'd0 : 2'd1;
        end
        st0 = $signed({3'b0, best_idx_reg}) - $signed({7'b0, back});
        st1 = (st0 < 0) ? st0 + $signed({2'b0, n_reg}) : st0;
        st2 = (st1 < 0) ? st1 + $signed({2'b0, n_reg}) : st1;
    end

    // next index modulo n
    logic [CNT_W-1:0] inc;
    logic [IDX_W-1:0] cur_next;
    always_comb
    begin
        inc      = {1'b0, cur_reg} + 7'd1;
        cur_next = (inc == n_reg) ? '0 : inc[IDX_W-1:0];
    end

    // repeated angles among the chosen neighbours
    logic dup;
    always_comb
    begin
        dup = (p_reg[0] == p_reg[1]);
        if (cubic_reg)
        begin
            dup = dup || (p_reg[0] == p_reg[2]) || (p_reg[0] == p_reg[3])
                || (p_reg[1] == p_reg[2]) || (p_reg[1] == p_reg[3])
                || (p_reg[2] == p_reg[3]);
        end
    end

    // factor magnitudes and shared multiplier
    logic signed [17:0] a_val, b_val;
    logic [15:0]        amag, bmag;
    logic [31:0]        mul_a;
    logic [15:0]        mul_b;
    logic [47:0]        prod;
    always_comb
    begin
        a_val = $signed({2'b0, HALF}) - $signed({2'b0, p_reg[j_reg[1:0]]});
        b_val = $signed({2'b0, p_reg[wi_reg]}) - $signed({2'b0, p_reg[j_reg[1:0]]});
        amag  = a_val[17] ? 16'(-a_val) : a_val[15:0];
        bmag  = b_val[17] ? 16'(-b_val) : b_val[15:0];
        case (ph_reg)
            2'd0:    mul_a = num_reg[31:0];
            2'd1:    mul_a = num_reg[63:32];
            2'd2:    mul_a = den_reg[31:0];
            default: mul_a = den_reg[63:32];
        endcase
        mul_b = ph_reg[1] ? bmag : amag;
        prod  = 48'(mul_a * mul_b);
    end

    logic [63:0] acc_next;
    assign acc_next = {prod[31:0], 32'b0} + {16'b0, lo_reg};

    // divider compares and rounding
    logic        ovf, ge, rnd_up;
    logic [19:0] qr;
    logic [WT_W-1:0] mag;
    logic signed [WT_W-1:0] wt_val;
    always_comb
    begin
        ovf    = {4'b0, num_reg} >= ({4'b0, den_reg} << 19);
        ge     = {4'b0, rem_reg} >= dsh_reg;
        rnd_up = {rem_reg[62:0], 1'b0} >= den_reg;
        qr     = {1'b0, q_reg} + {19'b0, rnd_up};
        mag    = (sat_reg || qr > {2'b0, WLIM}) ? WLIM : qr[WT_W-1:0];
        if (neg_reg)
        begin
            wt_val = $signed(18'(18'd0 - mag));
        end
        else
        begin
            wt_val = $signed((mag == WLIM) ? WLIM - 18'd1 : mag);
        end
    end

    // control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            num_dir_reg   <= NUM_DIR_RESET;
            order_reg     <= ORDER_RESET;
            phi_reg       <= '0;
            n_reg         <= '0;
            cubic_reg     <= 1'b0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            best_dist_reg <= '0;
            best_idx_reg  <= '0;
            best_ang_reg  <= '0;
            cur_reg       <= '0;
            wi_reg        <= '0;
            j_reg         <= '0;
            ph_reg        <= '0;
            num_reg       <= '0;
            den_reg       <= '0;
            lo_reg        <= '0;
            neg_reg       <= 1'b0;
            rem_reg       <= '0;
            dsh_reg       <= '0;
            q_reg         <= '0;
            step_reg      <= '0;
            sat_reg       <= 1'b0;
            fault_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            o_fault_reg   <= 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                nb_reg[k]   <= '0;
                p_reg[k]    <= '0;
                wt_reg[k]   <= '0;
                o_nb_reg[k] <= '0;
                o_wt_reg[k] <= '0;
            end
        end
        else
        begin
            // register writes
            if (apb_wr)
            begin
                unique case (paddr[2])
                    REG_NUM_DIR: num_dir_reg <= pwdata[CNT_W-1:0];
                    REG_ORDER:   order_reg   <= pwdata[0];
                    default:     ;
                endcase
            end

            // result register valid
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && command == CMD_QUERY)
                    begin
                        phi_reg       <= angle;
                        n_reg         <= (num_dir_reg > 7'(MAX_DIR)) ? 7'(MAX_DIR)
                                                                     : num_dir_reg;
                        cubic_reg     <= order_reg;
                        best_dist_reg <= 17'h10000;
                        best_idx_reg  <= '0;
                        issue_reg     <= '0;
                        pend_reg      <= 1'b0;
                        fault_reg     <= (num_dir_reg == 7'd0);
                        for (int k = 0; k < 4; k++)
                        begin
                            nb_reg[k] <= '0;
                            wt_reg[k] <= '0;
                        end
                        state_reg <= (num_dir_reg == 7'd0) ? S_OUT : S_SCAN;
                    end
                end

                // one table read per cycle, compared in the cycle after its read
                S_SCAN:
                begin
                    if (pend_reg && near_dist < best_dist_reg)
                    begin
                        best_dist_reg <= near_dist;
                        best_idx_reg  <= pend_idx_reg;
                        best_ang_reg  <= ram_q;
                    end
                    if (issue_reg < n_reg)
                    begin
                        pend_reg     <= 1'b1;
                        pend_idx_reg <= issue_reg[IDX_W-1:0];
                        issue_reg    <= issue_reg + 7'd1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg && issue_reg == n_reg)
                    begin
                        state_reg <= S_PICK;
                    end
                end

                S_PICK:
                begin
                    cur_reg   <= st2[IDX_W-1:0];
                    issue_reg <= '0;
                    pend_reg  <= 1'b0;
                    state_reg <= S_RDN;
                end

                // read the neighbours and rotate them about the query
                S_RDN:
                begin
                    if (issue_reg < {4'b0, cnt})
                    begin
                        nb_reg[issue_reg[1:0]] <= cur_reg;
                        cur_reg      <= cur_next;
                        pend_reg     <= 1'b1;
                        pend_idx_reg <= issue_reg[IDX_W-1:0];
                        issue_reg    <= issue_reg + 7'd1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg)
                    begin
                        p_reg[pend_idx_reg[1:0]] <= ram_q + HALF - phi_reg;
                        if (issue_reg == {4'b0, cnt})
                        begin
                            state_reg <= S_FLT;
                        end
                    end
                end

                S_FLT:
                begin
                    fault_reg <= dup;
                    wi_reg    <= '0;
                    j_reg     <= '0;
                    ph_reg    <= '0;
                    num_reg   <= 64'd1 << FRAC_BITS;
                    den_reg   <= 64'd1;
                    neg_reg   <= 1'b0;
                    state_reg <= dup ? S_OUT : S_MUL;
                end

                // build numerator and denominator one factor at a time
                S_MUL:
                begin
                    if (j_reg == cnt)
                    begin
                        state_reg <= S_DPRE;
                    end
                    else if (j_reg[1:0] == wi_reg)
                    begin
                        j_reg <= j_reg + 3'd1;
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 2'd1;
                        case (ph_reg)
                            2'd0, 2'd2: lo_reg <= prod;
                            2'd1:       num_reg <= acc_next;
                            default:
                            begin
                                den_reg <= acc_next;
                                neg_reg <= neg_reg ^ a_val[17] ^ b_val[17];
                                j_reg   <= j_reg + 3'd1;
                            end
                        endcase
                    end
                end

                S_DPRE:
                begin
                    sat_reg   <= ovf;
                    rem_reg   <= num_reg;
                    dsh_reg   <= {4'b0, den_reg} << 18;
                    q_reg     <= '0;
                    step_reg  <= 5'd18;
                    state_reg <= ovf ? S_RND : S_DIV;
                end

                // restoring division, one quotient bit per cycle
                S_DIV:
                begin
                    if (ge)
                    begin
                        rem_reg          <= rem_reg - dsh_reg[63:0];
                        q_reg[step_reg]  <= 1'b1;
                    end
                    dsh_reg <= dsh_reg >> 1;
                    if (step_reg == 5'd0)
                    begin
                        state_reg <= S_RND;
                    end
                    else
                    begin
                        step_reg <= step_reg - 5'd1;
                    end
                end

                S_RND:
                begin
                    wt_reg[wi_reg] <= wt_val;
                    wi_reg  <= wi_reg + 2'd1;
                    j_reg   <= '0;
                    ph_reg  <= '0;
                    num_reg <= 64'd1 << FRAC_BITS;
                    den_reg <= 64'd1;
                    neg_reg <= 1'b0;
                    state_reg <= ({1'b0, wi_reg} + 3'd1 == cnt) ? S_OUT : S_MUL;
                end

                // hand the word to the output register
                S_OUT:
                begin
                    if (out_load)
                    begin
                        o_fault_reg   <= fault_reg;
                        for (int k = 0; k < 4; k++)
                        begin
                            o_nb_reg[k] <= nb_reg[k];
                            o_wt_reg[k] <= fault_reg ? '0 : wt_reg[k];
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign nbr_a     = o_nb_reg[0];
    assign nbr_b     = o_nb_reg[1];
    assign nbr_c     = o_nb_reg[2];
    assign nbr_d     = o_nb_reg[3];
    assign wt_a      = o_wt_reg[0];
    assign wt_b      = o_wt_reg[1];
    assign wt_c      = o_wt_reg[2];
    assign wt_d      = o_wt_reg[3];
    assign fault     = o_fault_reg;

endmodule

// ----- src/cln_checker.sv -----
// Port-level checks for the circular Lagrange neighbour weight block, and its bind.
// Depends on cln_pkg and circular_lagrange_neighbour_weights_assert.svh.
`include "circular_lagrange_neighbour_weights_assert.svh"

module cln_checker
    import cln_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    command,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [IDX_W-1:0]        nbr_a,
    input logic signed [WT_W-1:0]  wt_a,
    input logic signed [WT_W-1:0]  wt_b,
    input logic signed [WT_W-1:0]  wt_c,
    input logic signed [WT_W-1:0]  wt_d,
    input logic                    fault
);

    // a stalled result word stays put
    `CLN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(nbr_a) && $stable(wt_a), "result word changed while stalled")

    // a query keeps the input busy on the next cycle
    `CLN_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && command == CMD_QUERY, in_stall, "input free right after a query")

    // a load never blocks the next word
    `CLN_ASSERT_NEXT(a_load_free, in_valid && !in_stall && command == CMD_LOAD, !in_stall, "input stalled after a load")

    // a faulted word carries no weights
    `CLN_ASSERT_NOW(a_fault_zero, out_valid && fault, wt_a == 0 && wt_b == 0 && wt_c == 0 && wt_d == 0, "weights nonzero on fault")

endmodule

bind circular_lagrange_neighbour_weights cln_checker u_cln_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .nbr_a     (nbr_a),
    .wt_a      (wt_a),
    .wt_b      (wt_b),
    .wt_c      (wt_c),
    .wt_d      (wt_d),
    .fault     (fault)
);
